// File: hw/rtl/apct_pkg.sv
// Package: shared types and constants of the atom pair clash test.
package apct_pkg;

    localparam int TypeBits = 5;
    typedef logic signed [TypeBits-1:0] t_atom;

    // Atom codes
    localparam t_atom T_N        = 5'sd0;
    localparam t_atom T_CA       = 5'sd1;
    localparam t_atom T_C        = 5'sd2;
    localparam t_atom T_O        = 5'sd3;
    localparam t_atom T_SIDE     = 5'sd4;
    localparam t_atom T_SULPHUR  = 5'sd5;
    localparam t_atom T_PRO_CD   = 5'sd6;

    // Configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_CUT   = 1'b1;

    localparam int ScaleBits = 16;
    localparam int CutBits   = 12;
    localparam int RadBits   = 12;
    localparam int GapBits   = 16;

    // 1.0 in Q1.15
    localparam logic [ScaleBits-1:0] SCALE_ONE = 16'h8000;

    // Pair classification from codes, residue gap and image flag
    typedef struct packed {
        logic skip;       // pair can never clash
        logic sidechain;  // scale the radius sum
        logic sulfur_cut; // subtract the scaled sulphur reduction
    } t_pair_flags;

endpackage

// File: hw/rtl/apct_pair_filter.sv
// Pair filter: dummy, same-residue and bonded-neighbor exclusions plus radius modifiers.
module apct_pair_filter (
    input  apct_pkg::t_atom       i_type_a,
    input  apct_pkg::t_atom       i_type_b,
    input  logic signed [15:0]    i_residue_gap,
    input  logic                  i_image,
    output apct_pkg::t_pair_flags o_flags
);

    logic dummy;
    logic gap_zero;
    logic gap_next;
    logic gap_prev;
    logic next_bonded;
    logic prev_bonded;

    always_comb begin
        dummy    = i_type_a[apct_pkg::TypeBits-1] || i_type_b[apct_pkg::TypeBits-1];
        gap_zero = (i_residue_gap == 16'sd0);
        gap_next = (i_residue_gap == 16'sd1);
        gap_prev = (i_residue_gap == -16'sd1);

        // first atom is one residue ahead: ahead = a, behind = b
        next_bonded = (i_type_a == apct_pkg::T_PRO_CD && i_type_b == apct_pkg::T_C)
            || ((i_type_a == apct_pkg::T_N || i_type_a == apct_pkg::T_CA)
                && (i_type_b == apct_pkg::T_CA || i_type_b == apct_pkg::T_C
                    || i_type_b == apct_pkg::T_O));
        // second atom is one residue ahead: ahead = b, behind = a
        prev_bonded = (i_type_a == apct_pkg::T_C && i_type_b == apct_pkg::T_PRO_CD)
            || ((i_type_b == apct_pkg::T_N || i_type_b == apct_pkg::T_CA)
                && (i_type_a == apct_pkg::T_CA || i_type_a == apct_pkg::T_C
                    || i_type_a == apct_pkg::T_O));

        o_flags.skip = dummy || (!i_image && (gap_zero || (gap_next && next_bonded)
                                              || (gap_prev && prev_bonded)));
        o_flags.sidechain = (i_type_a >= apct_pkg::T_SIDE) || (i_type_b >= apct_pkg::T_SIDE);
        o_flags.sulfur_cut = !i_image && (i_type_a == apct_pkg::T_SULPHUR)
                             && (i_type_b == apct_pkg::T_SULPHUR);
    end

endmodule

// File: hw/rtl/atom_pair_clash_test_top.sv
// Top level: five-stage sphere overlap pipeline, one pair per cycle unless stalled.
//
// Input channel: i_valid / o_stall with one port per pair field. A pair is
// transferred at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carrying o_overlap; a result is
// transferred at an edge with o_valid high and i_stall low.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index (0 sidechain
// scale, 1 sulphur cut) and i_cfg_data; o_cfg_ready is always high.
// Write configuration only while no pair is in flight.
// Pipeline: five register stages. Stages: decode and coordinate
// differences, radius products and absolute differences, radius sum and
// per-axis squares, radius square and box test, final distance compare
// into the output register.
// The widest multiplier is the 29 x 29 radius square.
// Throughput: one pair per cycle unless the output stalls.
// Stall: each stage advances when the stage after it is empty or moving, so
// bubbles collapse; o_stall rises only when all five stages are full and
// the receiver stalls. Stalled results hold unchanged.
// Reset: all stages empty, scale = 1.0 (Q1.15), sulphur cut = 0.
module atom_pair_clash_test_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [4:0]             i_type_a,
    input  logic signed [4:0]             i_type_b,
    input  logic signed [15:0]            i_residue_gap,
    input  logic [11:0]                   i_radius_a,
    input  logic [11:0]                   i_radius_b,
    input  logic signed [COORD_BITS-1:0]  i_ax,
    input  logic signed [COORD_BITS-1:0]  i_ay,
    input  logic signed [COORD_BITS-1:0]  i_az,
    input  logic signed [COORD_BITS-1:0]  i_bx,
    input  logic signed [COORD_BITS-1:0]  i_by,
    input  logic signed [COORD_BITS-1:0]  i_bz,
    input  logic                          i_image,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_overlap,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    // difference width, and width wide enough to slice the 14-bit low part
    localparam int DW = COORD_BITS + 1;
    localparam int EW = (DW > 14) ? DW : 15;

    // ---------------- configuration registers ----------------
    logic [15:0] r_scale;
    logic [11:0] r_cut;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= apct_pkg::SCALE_ONE;
            r_cut   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == apct_pkg::CFG_SCALE) begin
                r_scale <= i_cfg_data;
            end else begin
                r_cut <= i_cfg_data[11:0];
            end
        end
    end

    // ---------------- flow control ----------------
    // A stage loads when it is empty or its content moves on.
    logic r_v1, r_v2, r_v3, r_v4, r_o_valid;
    logic en1, en2, en3, en4, en5;

    assign en5     = !r_o_valid || !i_stall;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_o_valid <= r_v4;
        end
    end

    // ---------------- stage 1: decode, radius add, coordinate differences ----------------
    apct_pkg::t_pair_flags flags;

    apct_pair_filter u_filter (
        .i_type_a      (i_type_a),
        .i_type_b      (i_type_b),
        .i_residue_gap (i_residue_gap),
        .i_image       (i_image),
        .o_flags       (flags)
    );

    logic [DW-1:0] n_diff [3];
    logic [DW-1:0] r_diff1 [3];
    logic          r_skip1;
    logic          r_cut_en1;
    logic [12:0]   r_sum1;
    logic [15:0]   r_fac1;

    always_comb begin
        n_diff[0] = {i_ax[COORD_BITS-1], i_ax} - {i_bx[COORD_BITS-1], i_bx};
        n_diff[1] = {i_ay[COORD_BITS-1], i_ay} - {i_by[COORD_BITS-1], i_by};
        n_diff[2] = {i_az[COORD_BITS-1], i_az} - {i_bz[COORD_BITS-1], i_bz};
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_skip1   <= flags.skip;
            r_cut_en1 <= flags.sulfur_cut;
            r_sum1    <= 13'(i_radius_a) + 13'(i_radius_b);
            r_fac1    <= flags.sidechain ? r_scale : apct_pkg::SCALE_ONE;
            for (int k = 0; k < 3; k++) begin
                r_diff1[k] <= n_diff[k];
            end
        end
    end

    // ---------------- stage 2: radius products, absolute differences ----------------
    logic [28:0]   r_prod_a2;
    logic [27:0]   r_prod_s2;
    logic [DW-1:0] r_d2 [3];
    logic          r_skip2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_skip2   <= r_skip1;
            r_prod_a2 <= 29'(r_sum1) * 29'(r_fac1);
            r_prod_s2 <= r_cut_en1 ? (28'(r_cut) * 28'(r_scale)) : '0;
            for (int k = 0; k < 3; k++) begin
                r_d2[k] <= r_diff1[k][DW-1] ? (~r_diff1[k] + 1'b1) : r_diff1[k];
            end
        end
    end

    // ---------------- stage 3: radius sum, per-axis squares ----------------
    // Only differences below 2^14 can pass the box test, so square 14 bits.
    logic [EW-1:0] d_ext [3];
    logic [29:0]   r_r3;
    logic [13:0]   r_dlo3 [3];
    logic          r_small3 [3];
    logic [27:0]   r_sq3 [3];
    logic          r_skip3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_ext[k] = EW'(r_d2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_skip3 <= r_skip2;
            r_r3    <= 30'(r_prod_a2) - 30'(r_prod_s2);
            for (int k = 0; k < 3; k++) begin
                r_dlo3[k]   <= d_ext[k][13:0];
                r_small3[k] <= (d_ext[k][EW-1:14] == '0);
                r_sq3[k]    <= 28'(d_ext[k][13:0]) * 28'(d_ext[k][13:0]);
            end
        end
    end

    // ---------------- stage 4: radius square, box test, distance sum ----------------
    // d * 2^15 <= R  <=>  d <= R >> 15 for R >= 0; negative R rejects all.
    logic [57:0] r2_full;
    logic        axis_pass;
    logic [27:0] r_r2hi4;
    logic [29:0] r_dist4;
    logic        r_pass4;
    logic        r_skip4;

    always_comb begin
        r2_full   = 58'(r_r3[28:0]) * 58'(r_r3[28:0]);
        axis_pass = !r_r3[29];
        for (int k = 0; k < 3; k++) begin
            axis_pass = axis_pass && r_small3[k] && (r_dlo3[k] <= r_r3[28:15]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_skip4 <= r_skip3;
            r_pass4 <= axis_pass;
            r_r2hi4 <= r2_full[57:30];
            r_dist4 <= 30'(r_sq3[0]) + 30'(r_sq3[1]) + 30'(r_sq3[2]);
        end
    end

    // ---------------- stage 5: final compare into the output register ----------------
    // dist * 2^30 <= R^2  <=>  dist <= R^2 >> 30
    logic r_overlap;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_overlap <= !r_skip4 && r_pass4 && (r_dist4 <= 30'(r_r2hi4));
        end
    end

    assign o_overlap = r_overlap;

    // ---------------- assertions ----------------
    // An excluded pair never reports a clash.
    a_skip_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en5 && r_skip4) |=> !o_overlap)
        else $error("excluded pair reported as clash");

    // A negative radius sum fails the box test.
    a_neg_sum_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_r3[29]) |-> !axis_pass)
        else $error("negative radius sum passed box test");

    // Input is held back only when every stage is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_o_valid && i_stall))
        else $error("input stalled with an empty stage");

    // A rising o_valid always comes from an item held in stage 4.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_v4))
        else $error("result without a pipelined item");

endmodule
